// ----- rtl/lmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared widths, defaults and register codes of the local maximum counter.
// ----------------------------------------------------------------------------
`default_nettype none

package lmc_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    // Register fields
    localparam int ROW_CNT_W = 13;
    localparam int COL_CNT_W = 11;
    localparam int ROW_POS_W = 12;
    localparam int ROW_LIMIT = 4096;
    localparam int COL_CNT_MAX = 2047;

    // Result
    localparam int PEAK_W = 23;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/lmc_sample_if.sv -----
// ----------------------------------------------------------------------------
// lmc_sample_if
// Valid/ready channel carrying one signed matrix sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmc_sample_if #(
    parameter int SAMPLE_BITS = lmc_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/lmc_count_if.sv -----
// ----------------------------------------------------------------------------
// lmc_count_if
// Valid/ready channel carrying the peak count of one finished frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmc_count_if;
    logic                        valid;
    logic                        ready;
    logic [lmc_pkg::PEAK_W-1:0]  peak_count;

    modport source (output valid, output peak_count, input ready);
    modport sink   (input valid, input peak_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/lmc_ram.sv -----
// ----------------------------------------------------------------------------
// lmc_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = lmc_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/local_maximum_counter_core.sv -----
// ----------------------------------------------------------------------------
// local_maximum_counter_core
// Counts 3x3 local maxima (ties count) of a raster-ordered signed matrix.
// ----------------------------------------------------------------------------
// Usage:
//   i_sample_ch takes one sample per transaction, row by row. Frame size
//   comes from row_count (0x0) and column_count (0x4) on the APB port; sizes
//   are clamped to 2..4096 rows and 2..MAX_COLUMNS columns. A write to
//   either register restarts the frame; write only while the block is idle.
//   o_count_ch gives one transaction per frame with the peak count.
//   Throughput: one sample per clock unless a frame end is held off. The
//   two previous rows sit in a single line memory of MAX_COLUMNS words,
//   read when a sample is taken and rewritten in the next cycle; a
//   3-column window of registers follows it. The count of a frame goes
//   through the pipeline registers into the output buffer. Results queue
//   in a 2-entry output buffer, so a stalled receiver does not stop the
//   stream; only the last sample of a frame is held off while an older
//   result still occupies the second entry or is still in the pipeline.
//   Reset (i_rst_n low, synchronous) returns sizes to 2x2, empties the
//   pipeline and buffer and starts a new frame. Line memory contents are
//   never used before they are written within a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module local_maximum_counter_core #(
    parameter int MAX_COLUMNS = lmc_pkg::MAX_COLUMNS_DEF,
    parameter int SAMPLE_BITS = lmc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lmc_sample_if.sink                           i_sample_ch,
    lmc_count_if.source                          o_count_ch,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lmc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [lmc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lmc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int W      = SAMPLE_BITS;
    localparam int ROW_W  = lmc_pkg::ROW_POS_W;
    localparam int PEAK_W = lmc_pkg::PEAK_W;
    localparam int INC_W  = 3;

    // column: [0] two rows up, [1] one row up, [2] current row
    typedef logic [2:0][W-1:0]        t_col;
    // block: [col][row], center at [1][1]
    typedef logic [2:0][2:0][W-1:0]   t_blk;

    typedef struct packed {
        logic col_zero;
        logic col_one;
        logic last_col;
        logic row_ge1;
        logic row_ge2;
        logic last_row;
        logic frame_end;
    } t_flags;

    // True when no present neighbor is strictly greater than the center.
    function automatic logic f_peak(input t_blk b, input logic lp, input logic rp,
                                    input logic upp, input logic dnp);
        logic greater;
        logic present;
        greater = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                present = ((i != 0) || lp) && ((i != 2) || rp) &&
                          ((j != 0) || upp) && ((j != 2) || dnp);
                if (!((i == 1) && (j == 1)) && present &&
                    ($signed(b[i][j]) > $signed(b[1][1]))) begin
                    greater = 1'b1;
                end
            end
        end
        return !greater;
    endfunction

    // ---------------- configuration ----------------
    logic [lmc_pkg::ROW_CNT_W-1:0] r_row_count;
    logic [lmc_pkg::COL_CNT_W-1:0] r_col_count;
    logic [ROW_W-1:0]              r_last_row;
    logic [COL_W-1:0]              r_last_col;
    logic [ROW_W-1:0]              n_last_row;
    logic [COL_W-1:0]              n_last_col;
    logic [lmc_pkg::ROW_CNT_W-1:0] wr_rows;
    logic [lmc_pkg::COL_CNT_W-1:0] wr_cols;
    logic                          cfg_wr;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign wr_rows = pwdata[lmc_pkg::ROW_CNT_W-1:0];
    assign wr_cols = pwdata[lmc_pkg::COL_CNT_W-1:0];
    assign pready  = 1'b1;

    always_comb begin
        if (wr_rows < lmc_pkg::ROW_CNT_W'(2)) begin
            n_last_row = ROW_W'(1);
        end else if (32'(wr_rows) > lmc_pkg::ROW_LIMIT) begin
            n_last_row = ROW_W'(lmc_pkg::ROW_LIMIT - 1);
        end else begin
            n_last_row = ROW_W'(wr_rows - lmc_pkg::ROW_CNT_W'(1));
        end
        if (wr_cols < lmc_pkg::COL_CNT_W'(2)) begin
            n_last_col = COL_W'(1);
        end else if (32'(wr_cols) > MAX_COLUMNS) begin
            n_last_col = COL_W'(MAX_COLUMNS - 1);
        end else begin
            n_last_col = COL_W'(wr_cols - lmc_pkg::COL_CNT_W'(1));
        end
    end

    always_comb begin
        unique case (paddr[2])
            lmc_pkg::REG_ROW_COUNT:    prdata = lmc_pkg::APB_DATA_W'(r_row_count);
            lmc_pkg::REG_COLUMN_COUNT: prdata = lmc_pkg::APB_DATA_W'(r_col_count);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- stage 0: accept, position ----------------
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_flags           s0_flags;
    logic             in_accept;
    logic             end_busy;

    logic             r_s1_valid;
    logic [COL_W-1:0] r_s1_addr;
    logic [W-1:0]     r_s1_sample;
    t_flags           r_s1_flags;

    logic             r_s2_valid;
    t_blk             r_s2_win;
    t_flags           r_s2_flags;
    t_col             r_h1;
    t_col             r_h2;

    logic             r_s3_valid;
    logic [INC_W-1:0] r_s3_inc;
    logic             r_s3_end;

    logic [PEAK_W-1:0] r_run;
    logic              r_out_valid;
    logic [PEAK_W-1:0] r_out_data;
    logic              r_skid_valid;
    logic [PEAK_W-1:0] r_skid_data;

    always_comb begin
        s0_flags.col_zero  = (r_col == '0);
        s0_flags.col_one   = (r_col == COL_W'(1));
        s0_flags.last_col  = (r_col == r_last_col);
        s0_flags.row_ge1   = (r_row != '0);
        s0_flags.row_ge2   = (r_row > ROW_W'(1));
        s0_flags.last_row  = (r_row == r_last_row);
        s0_flags.frame_end = s0_flags.last_col && s0_flags.last_row;
    end

    // Hold off a frame end until the previous result has a free slot.
    assign end_busy = r_skid_valid ||
                      (r_s1_valid && r_s1_flags.frame_end) ||
                      (r_s2_valid && r_s2_flags.frame_end) ||
                      (r_s3_valid && r_s3_end);
    assign i_sample_ch.ready = !(s0_flags.frame_end && end_busy);
    assign in_accept = i_sample_ch.valid && i_sample_ch.ready;

    // ---------------- line memory ----------------
    // Entry holds {row two up, row one up}. A column is rewritten in the cycle
    // after its read; its next read is at least two transactions later.
    logic [2*W-1:0] ram_rdata;
    logic [2*W-1:0] ram_wdata;
    t_col           s1_col;

    assign s1_col[0] = ram_rdata[2*W-1:W];
    assign s1_col[1] = ram_rdata[W-1:0];
    assign s1_col[2] = r_s1_sample;
    assign ram_wdata = {ram_rdata[W-1:0], r_s1_sample};

    lmc_ram #(
        .WIDTH (2 * W),
        .DEPTH (MAX_COLUMNS)
    ) u_lmc_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    // ---------------- stage 2: judge window ----------------
    t_blk             blk_ax;
    t_blk             blk_ay;
    t_blk             blk_bx;
    t_blk             blk_by;
    logic             pk_ax;
    logic             pk_ay;
    logic             pk_bx;
    logic             pk_by;
    logic [INC_W-1:0] n_inc;
    t_flags           f;

    always_comb begin
        f      = r_s2_flags;
        blk_ax = r_s2_win;
        for (int k = 0; k < 3; k++) begin
            blk_ay[k][0] = r_s2_win[k][1];
            blk_ay[k][1] = r_s2_win[k][2];
            blk_ay[k][2] = r_s2_win[k][2];
        end
        blk_bx[0] = r_s2_win[1];
        blk_bx[1] = r_s2_win[2];
        blk_bx[2] = r_s2_win[2];
        blk_by[0] = blk_ay[1];
        blk_by[1] = blk_ay[2];
        blk_by[2] = blk_ay[2];
        // A: center one column back; B: center at the last column.
        // X: center one row up; Y: center in the last row.
        pk_ax = !f.col_zero && f.row_ge1 &&
                f_peak(blk_ax, !f.col_one, 1'b1, f.row_ge2, 1'b1);
        pk_ay = !f.col_zero && f.last_row &&
                f_peak(blk_ay, !f.col_one, 1'b1, 1'b1, 1'b0);
        pk_bx = f.last_col && f.row_ge1 &&
                f_peak(blk_bx, 1'b1, 1'b0, f.row_ge2, 1'b1);
        pk_by = f.last_col && f.last_row &&
                f_peak(blk_by, 1'b1, 1'b0, 1'b1, 1'b0);
        n_inc = INC_W'(pk_ax) + INC_W'(pk_ay) + INC_W'(pk_bx) + INC_W'(pk_by);
    end

    // ---------------- stage 3: accumulate, output buffer ----------------
    logic [PEAK_W-1:0] n_total;
    logic              push;
    logic              pop;

    assign n_total = PEAK_W'(r_run + PEAK_W'(r_s3_inc));
    assign push    = r_s3_valid && r_s3_end;
    assign pop     = r_out_valid && o_count_ch.ready;

    assign o_count_ch.valid      = r_out_valid;
    assign o_count_ch.peak_count = r_out_data;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= lmc_pkg::ROW_CNT_W'(2);
            r_col_count  <= lmc_pkg::COL_CNT_W'(2);
            r_last_row   <= ROW_W'(1);
            r_last_col   <= COL_W'(1);
            r_col        <= '0;
            r_row        <= '0;
            r_run        <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;

            if (cfg_wr) begin
                unique case (paddr[2])
                    lmc_pkg::REG_ROW_COUNT: begin
                        r_row_count <= wr_rows;
                        r_last_row  <= n_last_row;
                    end
                    lmc_pkg::REG_COLUMN_COUNT: begin
                        r_col_count <= wr_cols;
                        r_last_col  <= n_last_col;
                    end
                    default: begin
                    end
                endcase
                // restart the frame
                r_col <= '0;
                r_row <= '0;
                r_run <= '0;
            end else begin
                if (in_accept) begin
                    if (s0_flags.last_col) begin
                        r_col <= '0;
                        r_row <= s0_flags.last_row ? '0 : ROW_W'(r_row + ROW_W'(1));
                    end else begin
                        r_col <= COL_W'(r_col + COL_W'(1));
                    end
                end
                if (r_s3_valid) begin
                    r_run <= r_s3_end ? '0 : n_total;
                end
            end

            priority if (pop) begin
                r_out_valid  <= r_skid_valid || push;
                r_skid_valid <= r_skid_valid && push;
            end else if (push) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr   <= r_col;
            r_s1_sample <= W'(i_sample_ch.sample);
            r_s1_flags  <= s0_flags;
        end
        if (r_s1_valid) begin
            r_s2_win[0] <= r_h2;
            r_s2_win[1] <= r_h1;
            r_s2_win[2] <= s1_col;
            r_s2_flags  <= r_s1_flags;
            r_h2        <= r_h1;
            r_h1        <= s1_col;
        end
        if (r_s2_valid) begin
            r_s3_inc <= n_inc;
            r_s3_end <= r_s2_flags.frame_end;
        end
        priority if (pop) begin
            r_out_data  <= r_skid_valid ? r_skid_data : n_total;
            r_skid_data <= n_total;
        end else if (push) begin
            if (r_out_valid) begin
                r_skid_data <= n_total;
            end else begin
                r_out_data <= n_total;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lmc_checker.sv -----
// ----------------------------------------------------------------------------
// lmc_checker
// Port-level checks on the result channel of the local maximum counter.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_checker #(
    parameter int MAX_COLUMNS = lmc_pkg::MAX_COLUMNS_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [lmc_pkg::PEAK_W-1:0] i_peak_count
);

    localparam int  COL_BOUND  = (MAX_COLUMNS < lmc_pkg::COL_CNT_MAX) ?
                                 MAX_COLUMNS : lmc_pkg::COL_CNT_MAX;
    localparam longint PEAK_BOUND = longint'(lmc_pkg::ROW_LIMIT) * longint'(COL_BOUND);

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its count.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_peak_count))
        else $error("peak count changed while stalled");

    // Every frame has at least its largest sample as a peak.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_peak_count != '0))
        else $error("frame reported without any peak");

    // A frame cannot hold more peaks than cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (64'(i_peak_count) <= 64'(PEAK_BOUND)))
        else $error("peak count exceeds largest frame");

endmodule

bind local_maximum_counter_core lmc_checker #(
    .MAX_COLUMNS (MAX_COLUMNS)
) u_lmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_count_ch.valid),
    .i_out_ready  (o_count_ch.ready),
    .i_peak_count (o_count_ch.peak_count)
);

`default_nettype wire

// ----- verif/tb_local_maximum_counter_core.sv -----
// ----------------------------------------------------------------------------
// tb_local_maximum_counter_core
// Self-checking regression of the 3x3 local maximum counter. A predictor in
// the bench follows every accepted sample, judges each row once the row
// below it (or the frame end) is in, and queues the peak count per frame.
// Each count transaction is compared with the oldest queued count. Frame
// sizes are set over APB while the block is idle; traffic covers ties,
// sample extremes, clamped sizes, restarts mid-frame, partial frames at the
// largest sizes, back-to-back streaming, a long output stall and random
// small frames.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_local_maximum_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_W          = lmc_pkg::SAMPLE_BITS_DEF;
    localparam int MAX_COLS          = lmc_pkg::MAX_COLUMNS_DEF;
    localparam int IDLE_PCT          = 28;
    localparam int DRAIN_CYCLES      = 10;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int EXTREME_ITEMS     = 30;
    localparam int RANDOM_ITEMS      = 260;
    localparam int RANDOM_FRAMES_MIN = 8;
    localparam int RUN_LIMIT_NS      = 5_000_000;

    // Line buffers of the predictor
    localparam int LINE_NONE   = -1;
    localparam int LINE_UPPER  = 0;
    localparam int LINE_MIDDLE = 1;
    localparam int LINE_LOWER  = 2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [lmc_pkg::APB_ADDR_W-1:0] paddr   = '0;
    logic [lmc_pkg::APB_DATA_W-1:0] pwdata  = '0;
    logic [lmc_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    lmc_sample_if #(.SAMPLE_BITS(SAMPLE_W)) sample_ch ();
    lmc_count_if                            count_ch ();

    local_maximum_counter_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_count_ch  (count_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [lmc_pkg::ROW_CNT_W-1:0] row_setting = lmc_pkg::ROW_CNT_W'(2);
    logic [lmc_pkg::COL_CNT_W-1:0] col_setting = lmc_pkg::COL_CNT_W'(2);
    t_sample                       line_store [3][MAX_COLS];
    int                            col_pos = 0;
    int                            row_pos = 0;
    logic [lmc_pkg::PEAK_W-1:0]    peaks_so_far = '0;
    logic [lmc_pkg::PEAK_W-1:0]    expected_counts [$];

    int fail_count     = 0;
    int samples_taken  = 0;
    int counts_checked = 0;
    bit steady         = 1'b0;
    int hold_off_left  = 0;

    function automatic int effective_rows();
        int r;
        r = row_setting;
        if (r < 2) r = 2;
        if (r > lmc_pkg::ROW_LIMIT) r = lmc_pkg::ROW_LIMIT;
        return r;
    endfunction

    function automatic int effective_cols();
        int c;
        c = col_setting;
        if (c < 2) c = 2;
        if (c > MAX_COLS) c = MAX_COLS;
        return c;
    endfunction

    function automatic bit neighbour_greater(int line, int x, int cols, t_sample v);
        int lo;
        int hi;
        lo = (x == 0) ? 0 : x - 1;
        hi = (x + 1 >= cols) ? cols - 1 : x + 1;
        for (int k = lo; k <= hi; k++)
            if (line_store[line][k] > v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void tally_row(int above, int centre, int below, int cols);
        t_sample v;
        bit      beaten;
        for (int x = 0; x < cols; x++) begin
            v = line_store[centre][x];
            beaten = neighbour_greater(centre, x, cols, v);
            if (above != LINE_NONE && neighbour_greater(above, x, cols, v)) beaten = 1'b1;
            if (below != LINE_NONE && neighbour_greater(below, x, cols, v)) beaten = 1'b1;
            if (!beaten) peaks_so_far = peaks_so_far + 1'b1;
        end
    endfunction

    function automatic void take_sample(t_sample s);
        int cols;
        int rows;
        cols = effective_cols();
        rows = effective_rows();
        if (col_pos >= cols) col_pos = 0;
        if (row_pos >= rows) row_pos = 0;
        line_store[LINE_LOWER][col_pos] = s;
        col_pos++;
        if (col_pos < cols) return;
        col_pos = 0;
        // Judge the row above now that the row below it is complete
        if (row_pos >= 1)
            tally_row((row_pos >= 2) ? LINE_UPPER : LINE_NONE, LINE_MIDDLE, LINE_LOWER, cols);
        if (row_pos + 1 >= rows) begin
            tally_row(LINE_MIDDLE, LINE_LOWER, LINE_NONE, cols);
            expected_counts = {expected_counts, peaks_so_far};
            peaks_so_far = '0;
            row_pos = 0;
            return;
        end
        for (int k = 0; k < cols; k++) begin
            line_store[LINE_UPPER][k]  = line_store[LINE_MIDDLE][k];
            line_store[LINE_MIDDLE][k] = line_store[LINE_LOWER][k];
        end
        row_pos++;
    endfunction

    function automatic void apply_register(logic idx, logic [lmc_pkg::APB_DATA_W-1:0] value);
        if (idx == lmc_pkg::REG_ROW_COUNT) row_setting = value[lmc_pkg::ROW_CNT_W-1:0];
        else col_setting = value[lmc_pkg::COL_CNT_W-1:0];
        col_pos = 0;
        row_pos = 0;
        peaks_so_far = '0;
    endfunction

    // Follow accepted samples and check each count transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                take_sample(sample_ch.sample);
                samples_taken++;
            end
            if (count_ch.valid && count_ch.ready) begin
                if (expected_counts.size() == 0) begin
                    $error("peak_count: expected none, actual %0d", count_ch.peak_count);
                    fail_count++;
                end else begin
                    if (count_ch.peak_count !== expected_counts[0]) begin
                        $error("peak_count: expected %0d, actual %0d",
                               expected_counts[0], count_ch.peak_count);
                        fail_count++;
                    end
                    void'(expected_counts.pop_front());
                    counts_checked++;
                end
            end
        end
    end

    // Receiver: random back-pressure, or a counted hold-off when requested
    initial begin
        count_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                count_ch.ready <= 1'b0;
                hold_off_left--;
            end else begin
                count_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic t_sample pick_sample();
        int mode;
        mode = $urandom_range(7);
        case (mode)
            0, 1: return t_sample'($urandom);
            2, 3: return t_sample'(int'($urandom_range(4)) - 2);
            4: begin
                if ($urandom_range(1)) return {1'b0, {(SAMPLE_W-1){1'b1}}};
                return {1'b1, {(SAMPLE_W-1){1'b0}}};
            end
            default: return t_sample'(int'($urandom_range(40)) - 20);
        endcase
    endfunction

    // Called and returns at a falling edge
    task automatic send_sample(t_sample s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= t_sample'($urandom);
            @(negedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(int n);
        repeat (n) send_sample(pick_sample());
    endtask

    // Drop valid, wait for every queued count, then let the pipeline empty
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (expected_counts.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic idx, logic [lmc_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_size(int rows, int cols);
        write_register(lmc_pkg::REG_ROW_COUNT, rows);
        write_register(lmc_pkg::REG_COLUMN_COUNT, cols);
    endtask

    task automatic test_default_size();
        // Flat frame: every cell ties with its neighbors; then sample extremes
        repeat (4) send_sample('0);
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        repeat (3) send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        settle();
    endtask

    task automatic test_restart_on_write();
        int frame_vals [9] = '{1, 5, 1, 2, 9, 2, 9, 0, -3};
        set_size(3, 3);
        send_random(5);
        settle();
        // Abandon the partial frame
        write_register(lmc_pkg::REG_ROW_COUNT, 3);
        foreach (frame_vals[i]) send_sample(t_sample'(frame_vals[i]));
        settle();
    endtask

    task automatic test_size_clamp();
        set_size(0, 1);
        send_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
        send_sample('0);
        settle();
        set_size(1, 0);
        send_random(4);
        settle();
    endtask

    task automatic test_size_extremes();
        int sizes [4][2] = '{'{4096, 2}, '{8191, 2}, '{2, 1024}, '{2, 2047}};
        foreach (sizes[i]) begin
            set_size(sizes[i][0], sizes[i][1]);
            // Partial frame only; the next register write restarts it
            send_random(EXTREME_ITEMS);
            settle();
        end
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        set_size(3, 5);
        send_random(15 * 6);
        settle();
        steady = 1'b0;
    endtask

    task automatic test_output_stall();
        set_size(2, 2);
        hold_off_left = HOLD_OFF_CYCLES;
        send_random(4 * 12);
        settle();
    endtask

    task automatic test_random_frames();
        int items;
        int frames;
        int rows;
        int cols;
        int len;
        int cut;
        items  = 0;
        frames = 0;
        while (items < RANDOM_ITEMS || frames < RANDOM_FRAMES_MIN) begin
            rows = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(6, 2);
            case ($urandom_range(9))
                0:       cols = $urandom_range(1);
                1:       cols = $urandom_range(40, 10);
                default: cols = $urandom_range(9, 2);
            endcase
            if ($urandom_range(1)) begin
                write_register(lmc_pkg::REG_COLUMN_COUNT, cols);
                write_register(lmc_pkg::REG_ROW_COUNT, rows);
            end else begin
                set_size(rows, cols);
            end
            repeat ($urandom_range(3, 1)) begin
                len = effective_rows() * effective_cols();
                if ($urandom_range(7) == 0) begin
                    // Broken frame, then restart it with a register write
                    cut = $urandom_range(len - 1, 1);
                    send_random(cut);
                    items += cut;
                    settle();
                    if ($urandom_range(1)) write_register(lmc_pkg::REG_ROW_COUNT, rows);
                    else write_register(lmc_pkg::REG_COLUMN_COUNT, cols);
                end
                send_random(len);
                items += len;
                frames++;
            end
            settle();
        end
    endtask

    initial begin
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_size();
        test_restart_on_write();
        test_size_clamp();
        test_size_extremes();
        test_back_to_back();
        test_output_stall();
        test_random_frames();

        $display("Run covered %0d samples and %0d frame counts, sizes from clamped 2x2",
                 samples_taken, counts_checked);
        $display("to 40 columns, partial frames at the largest sizes, restarts and a stall.");
        if (fail_count == 0) begin
            $display("local_maximum_counter_core regression: pass");
        end else begin
            $display("local_maximum_counter_core regression: fail");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("local_maximum_counter_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
